// File: src/rlf_pkg.sv
// shared types, constants and helpers for the rgb led fade serializer
package rlf_pkg;

  localparam int FRAME_BITS = 24;
  localparam int BITS_W     = $clog2(FRAME_BITS + 1);
  localparam int CHANNELS   = 3;
  localparam int DIV_STEPS  = 16;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

  localparam logic [1:0] REQ_SET   = 2'd0;
  localparam logic [1:0] REQ_FRAME = 2'd1;
  localparam logic [1:0] REQ_TICK  = 2'd2;

  localparam logic [15:0] COLOUR_MAX = 16'hFF00;
  localparam logic [7:0]  FADE_RESET = 8'd16;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] target_green;
    logic [7:0] target_red;
    logic [7:0] target_blue;
  } in_item_t;

  typedef struct packed {
    logic line_level;
    logic busy_res;
    logic frame_done;
  } out_item_t;

  typedef struct packed {
    logic [7:0] zero_high;
    logic [7:0] zero_low;
    logic [7:0] one_high;
    logic [7:0] one_low;
  } timing_t;

  // a zero register value behaves as one
  function automatic logic [7:0] at_least_one(input logic [7:0] v);
    return (v == 8'd0) ? 8'd1 : v;
  endfunction

endpackage

// File: src/rlf_div.sv
// bit-serial restoring divider, 16-bit magnitude by 8-bit divisor, sign applied at the end
module rlf_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [15:0] magnitude,
  input  logic        negative,
  input  logic [7:0]  divisor,
  output logic        done,
  output logic [17:0] quotient
);

  logic [rlf_pkg::DIV_CNT_W-1:0] cnt;
  logic [15:0] quo;
  logic [7:0]  rem;
  logic [7:0]  dvs;
  logic        neg;
  logic [8:0]  trial;
  logic        ge;

  assign trial = {rem, quo[15]};
  assign ge    = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else if (start) begin
      cnt  <= rlf_pkg::DIV_CNT_W'(rlf_pkg::DIV_STEPS);
      done <= 1'b0;
    end else if (cnt != '0) begin
      cnt  <= cnt - 1'b1;
      done <= (cnt == rlf_pkg::DIV_CNT_W'(1));
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= magnitude;
      rem <= '0;
      dvs <= divisor;
      neg <= negative;
    end else if (cnt != '0) begin
      rem <= ge ? 8'(trial - {1'b0, dvs}) : trial[7:0];
      quo <= {quo[14:0], ge};
    end
  end

  assign quotient = neg ? 18'(-{2'b00, quo}) : {2'b00, quo};

endmodule

// File: src/rlf_fade.sv
// colour fade state: target load with serial per-channel division and per-frame step
module rlf_fade (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  set_target,
  input  logic                  frame_step,
  input  logic [2:0][7:0]       goal_in,
  input  logic [7:0]            fade_steps,
  output logic                  busy,
  output logic [23:0]           frame_word
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOAD = 2'd1;
  localparam logic [1:0] S_WAIT = 2'd2;

  logic [1:0]  state;
  logic [1:0]  chan;
  logic [7:0]  steps_held;
  logic [15:0] colour_now  [rlf_pkg::CHANNELS];
  logic [17:0] colour_step [rlf_pkg::CHANNELS];
  logic [7:0]  colour_goal [rlf_pkg::CHANNELS];
  logic [7:0]  fade_count;

  logic [7:0]  steps_now;
  logic [7:0]  fc_inc;
  logic        fc_below;
  logic        snap;
  logic [15:0] colour_new [rlf_pkg::CHANNELS];

  logic [16:0] diff;
  logic [15:0] mag;
  logic        div_done;
  logic [17:0] div_q;

  assign steps_now = rlf_pkg::at_least_one(fade_steps);
  assign fc_inc    = fade_count + 8'd1;
  assign fc_below  = fade_count < steps_now;
  assign snap      = !fc_below || (fc_inc >= steps_now);

  always_comb begin
    logic signed [18:0] sum;
    for (int c = 0; c < rlf_pkg::CHANNELS; c++) begin
      sum = $signed({3'b000, colour_now[c]}) + $signed({colour_step[c][17], colour_step[c]});
      if (snap) begin
        colour_new[c] = {colour_goal[c], 8'h00};
      end else if (sum < 0) begin
        colour_new[c] = 16'h0000;
      end else if (sum > $signed({3'b000, rlf_pkg::COLOUR_MAX})) begin
        colour_new[c] = rlf_pkg::COLOUR_MAX;
      end else begin
        colour_new[c] = sum[15:0];
      end
    end
  end

  // green, red, blue integer parts
  assign frame_word = {colour_new[0][15:8], colour_new[1][15:8], colour_new[2][15:8]};

  // (goal << 8) - current for the channel under division
  assign diff = {1'b0, colour_goal[chan], 8'h00} - {1'b0, colour_now[chan]};
  assign mag  = diff[16] ? 16'(-diff) : diff[15:0];

  rlf_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (state == S_LOAD),
    .magnitude (mag),
    .negative  (diff[16]),
    .divisor   (steps_held),
    .done      (div_done),
    .quotient  (div_q)
  );

  assign busy = state != S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      chan       <= '0;
      steps_held <= 8'd1;
      fade_count <= rlf_pkg::FADE_RESET;
      for (int c = 0; c < rlf_pkg::CHANNELS; c++) begin
        colour_now[c]  <= '0;
        colour_step[c] <= '0;
        colour_goal[c] <= '0;
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          if (set_target) begin
            for (int c = 0; c < rlf_pkg::CHANNELS; c++) begin
              colour_goal[c] <= goal_in[2-c];
            end
            steps_held <= steps_now;
            fade_count <= '0;
            chan       <= '0;
            state      <= S_LOAD;
          end else if (frame_step) begin
            for (int c = 0; c < rlf_pkg::CHANNELS; c++) begin
              colour_now[c] <= colour_new[c];
            end
            if (fc_below) begin
              fade_count <= fc_inc;
            end
          end
        end
        S_LOAD: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (div_done) begin
            colour_step[chan] <= div_q;
            if (chan == 2'd2) begin
              state <= S_IDLE;
            end else begin
              chan  <= chan + 2'd1;
              state <= S_LOAD;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: src/rlf_line.sv
// one-wire line encoder: frame shift register, bit counter and phase timer
module rlf_line (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  logic [23:0]          word,
  input  logic                 tick,
  input  rlf_pkg::timing_t     timing,
  output logic                 busy,
  output logic                 in_high,
  output logic                 done
);

  localparam int MSB = rlf_pkg::FRAME_BITS - 1;

  logic [rlf_pkg::FRAME_BITS-1:0] frame_shift;
  logic [rlf_pkg::BITS_W-1:0]     bits_left;
  logic [7:0]                     phase_timer;
  logic [rlf_pkg::FRAME_BITS-1:0] word_ext;
  logic [7:0]                     timer_dec;
  logic                           last_bit;

  assign word_ext  = rlf_pkg::FRAME_BITS'(word) << (rlf_pkg::FRAME_BITS - 24);
  assign busy      = bits_left != '0;
  assign timer_dec = phase_timer - 8'd1;
  assign last_bit  = bits_left == rlf_pkg::BITS_W'(1);
  assign done      = tick && busy && (timer_dec == 8'd0) && !in_high && last_bit;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_shift <= '0;
      bits_left   <= '0;
      phase_timer <= '0;
      in_high     <= 1'b0;
    end else if (load) begin
      frame_shift <= word_ext;
      bits_left   <= rlf_pkg::BITS_W'(rlf_pkg::FRAME_BITS);
      in_high     <= 1'b1;
      phase_timer <= rlf_pkg::at_least_one(word_ext[MSB] ? timing.one_high : timing.zero_high);
    end else if (tick && busy) begin
      if (timer_dec != 8'd0) begin
        phase_timer <= timer_dec;
      end else if (in_high) begin
        in_high     <= 1'b0;
        phase_timer <= rlf_pkg::at_least_one(frame_shift[MSB] ? timing.one_low
                                                              : timing.zero_low);
      end else begin
        frame_shift <= frame_shift << 1;
        bits_left   <= bits_left - 1'b1;
        if (last_bit) begin
          in_high     <= 1'b0;
          phase_timer <= timer_dec;
        end else begin
          in_high     <= 1'b1;
          phase_timer <= rlf_pkg::at_least_one(frame_shift[MSB-1] ? timing.one_high
                                                                  : timing.zero_high);
        end
      end
    end
  end

endmodule

// File: src/rgb_led_fade_serializer.sv
// top level of the rgb led fade serializer: handshake, register port, fade and line encoder
// output: every accepted item gives its result in the output register in the next cycle
// throughput: tick and frame items, one per cycle while the result side keeps up
// set target: after it is accepted the input stalls while the shared bit-serial divider
//   handles the colour channels in turn (one quotient bit per cycle, 16 bits per channel)
// reset: synchronous; registers to their defaults, colours zero, line idle
module rgb_led_fade_serializer (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  rlf_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output rlf_pkg::out_item_t out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  // register indexes on the port
  localparam logic [2:0] REG_FADE_STEPS = 3'd0;
  localparam logic [2:0] REG_ZERO_HIGH  = 3'd1;
  localparam logic [2:0] REG_ZERO_LOW   = 3'd2;
  localparam logic [2:0] REG_ONE_HIGH   = 3'd3;
  localparam logic [2:0] REG_ONE_LOW    = 3'd4;

  logic [7:0]        fade_steps;
  rlf_pkg::timing_t  timing;

  logic              accept;
  logic              is_set;
  logic              is_frame;
  logic              is_tick;
  logic              frame_load;
  logic              fade_busy;
  logic [23:0]       frame_word;
  logic              line_busy;
  logic              line_high;
  logic              line_done;
  rlf_pkg::out_item_t result;

  // register port, writes land on the access cycle
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fade_steps       <= 8'd16;
      timing.zero_high <= 8'd1;
      timing.zero_low  <= 8'd6;
      timing.one_high  <= 8'd3;
      timing.one_low   <= 8'd3;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[4:2])
        REG_FADE_STEPS: fade_steps       <= pwdata[7:0];
        REG_ZERO_HIGH:  timing.zero_high <= pwdata[7:0];
        REG_ZERO_LOW:   timing.zero_low  <= pwdata[7:0];
        REG_ONE_HIGH:   timing.one_high  <= pwdata[7:0];
        REG_ONE_LOW:    timing.one_low   <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_FADE_STEPS: prdata = {24'd0, fade_steps};
      REG_ZERO_HIGH:  prdata = {24'd0, timing.zero_high};
      REG_ZERO_LOW:   prdata = {24'd0, timing.zero_low};
      REG_ONE_HIGH:   prdata = {24'd0, timing.one_high};
      REG_ONE_LOW:    prdata = {24'd0, timing.one_low};
      default:        prdata = 32'd0;
    endcase
  end

  // hold input while a division runs or the result register is full and stalled
  assign in_stall = fade_busy || (out_valid && out_stall);
  assign accept   = in_valid && !in_stall;
  assign is_set   = in_data.req_type == rlf_pkg::REQ_SET;
  assign is_frame = in_data.req_type == rlf_pkg::REQ_FRAME;
  assign is_tick  = in_data.req_type == rlf_pkg::REQ_TICK;

  // a frame only starts when the line is idle, otherwise it is dropped
  assign frame_load = accept && is_frame && !line_busy;

  rlf_fade u_fade (
    .clk        (clk),
    .rst        (rst),
    .set_target (accept && is_set),
    .frame_step (frame_load),
    .goal_in    ({in_data.target_green, in_data.target_red, in_data.target_blue}),
    .fade_steps (fade_steps),
    .busy       (fade_busy),
    .frame_word (frame_word)
  );

  rlf_line u_line (
    .clk     (clk),
    .rst     (rst),
    .load    (frame_load),
    .word    (frame_word),
    .tick    (accept && is_tick),
    .timing  (timing),
    .busy    (line_busy),
    .in_high (line_high),
    .done    (line_done)
  );

  // the high flag is clear whenever the line is idle, so one form covers all items:
  // a tick shows the current phase, other items show the level the next tick drives
  assign result.line_level = frame_load || line_high;
  assign result.busy_res   = frame_load || line_busy;
  assign result.frame_done = line_done;

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= result;
    end
  end

  // a frame taken on an idle line starts sending
  a_frame_starts: assert property (@(posedge clk) disable iff (rst)
    frame_load |=> line_busy && line_high)
    else $error("frame did not start sending");

  // a target load holds off the next item
  a_set_stalls: assert property (@(posedge clk) disable iff (rst)
    (accept && is_set) |=> in_stall)
    else $error("input not held during division");

  // end of frame is only reported on a busy tick
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.frame_done) |-> out_data.busy_res)
    else $error("frame done without busy");

  // the line never reads high while idle
  a_idle_low: assert property (@(posedge clk) disable iff (rst)
    !line_busy |-> !line_high)
    else $error("line high while idle");

endmodule

// File: tb/tb_rgb_led_fade_serializer.sv
// testbench for the rgb led fade serializer: directed table, random fades, line-level prediction
`timescale 1ns / 100ps

module tb_rgb_led_fade_serializer;

  // request code the block must ignore
  localparam logic [1:0] REQ_NONE = 2'd3;

  // register indexes, byte address is four times the index
  typedef enum int {
    REG_FADE_STEPS = 0,
    REG_ZERO_HIGH  = 1,
    REG_ZERO_LOW   = 2,
    REG_ONE_HIGH   = 3,
    REG_ONE_LOW    = 4
  } reg_idx_e;

  typedef enum int {ROW_ITEM, ROW_CFG} row_kind_e;

  // one line of the directed table
  typedef struct {
    row_kind_e  kind;
    logic [1:0] req;
    logic [7:0] g;
    logic [7:0] r;
    logic [7:0] b;
    int         reps;
    bit         typed;
    logic [2:0] res;
    reg_idx_e   idx;
    logic [7:0] val;
  } row_t;

  localparam int UNTIL_IDLE  = 0;  // reps value: send ticks until the frame is out
  localparam int N_DIR       = 24;
  localparam int N_PHASES    = 2;
  localparam int PHASE_ITEMS = 40;
  localparam int LONG_TICKS  = 20;
  localparam int DRAIN_PAD   = 4;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  rlf_pkg::in_item_t   in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  rlf_pkg::out_item_t  out_data;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [4:0]          paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;

  rgb_led_fade_serializer uut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // hard stop well past the slowest legal run
  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // line predictor: fade state, frame shifter and phase timer of the block
  // ---------------------------------------------------------------------------
  logic [7:0]                     reg_val [5];
  logic [15:0]                    cur_col [3];   // 8.8 colour, green red blue
  logic signed [17:0]             col_inc [3];   // 8.8 per-frame increment
  logic [7:0]                     goal_col [3];
  logic [7:0]                     fade_idx;
  logic [rlf_pkg::FRAME_BITS-1:0] shift_word;
  logic [rlf_pkg::BITS_W-1:0]     bits_todo;
  logic [7:0]                     ticks_left;
  logic                           high_phase;

  // results still owed by the block, oldest first
  rlf_pkg::out_item_t line_q [$];

  int errors;
  int items_sent;
  int ctl_sent;     // non-tick items
  int results_seen;
  int frames_seen;
  int stall_left;

  function automatic logic [7:0] eff(input logic [7:0] v);
    return (v == 8'd0) ? 8'd1 : v;
  endfunction

  function automatic void load_phase(input logic hi);
    logic b;
    b = shift_word[rlf_pkg::FRAME_BITS-1];
    high_phase = hi;
    if (hi)
      ticks_left = eff(b ? reg_val[REG_ONE_HIGH] : reg_val[REG_ZERO_HIGH]);
    else
      ticks_left = eff(b ? reg_val[REG_ONE_LOW] : reg_val[REG_ZERO_LOW]);
  endfunction

  function automatic void reset_line_state();
    reg_val[REG_FADE_STEPS] = rlf_pkg::FADE_RESET;
    reg_val[REG_ZERO_HIGH]  = 8'd1;
    reg_val[REG_ZERO_LOW]   = 8'd6;
    reg_val[REG_ONE_HIGH]   = 8'd3;
    reg_val[REG_ONE_LOW]    = 8'd3;
    for (int c = 0; c < rlf_pkg::CHANNELS; c++) begin
      cur_col[c]  = '0;
      col_inc[c]  = '0;
      goal_col[c] = '0;
    end
    fade_idx   = rlf_pkg::FADE_RESET;
    shift_word = '0;
    bits_todo  = '0;
    ticks_left = '0;
    high_phase = 1'b0;
  endfunction

  function automatic rlf_pkg::out_item_t predict_line(input rlf_pkg::in_item_t it);
    rlf_pkg::out_item_t o;
    logic [7:0] steps;
    int diff;
    int v;
    bit snap;
    o = '0;
    if (it.req_type == rlf_pkg::REQ_TICK) begin
      if (bits_todo != 0) begin
        o.line_level = high_phase;
        o.busy_res   = 1'b1;
        ticks_left   = ticks_left - 8'd1;
        if (ticks_left == 8'd0) begin
          if (high_phase) begin
            load_phase(1'b0);
          end else begin
            shift_word = shift_word << 1;
            bits_todo  = bits_todo - 1'b1;
            if (bits_todo == 0) begin
              high_phase   = 1'b0;
              o.frame_done = 1'b1;
            end else begin
              load_phase(1'b1);
            end
          end
        end
      end
    end else begin
      if (it.req_type == rlf_pkg::REQ_SET) begin
        // new goal, increment taken from where the colour stands now
        steps       = eff(reg_val[REG_FADE_STEPS]);
        goal_col[0] = it.target_green;
        goal_col[1] = it.target_red;
        goal_col[2] = it.target_blue;
        for (int c = 0; c < rlf_pkg::CHANNELS; c++) begin
          diff       = int'({goal_col[c], 8'h00}) - int'(cur_col[c]);
          col_inc[c] = 18'(diff / int'(steps));
        end
        fade_idx = '0;
      end else if (it.req_type == rlf_pkg::REQ_FRAME && bits_todo == 0) begin
        steps = eff(reg_val[REG_FADE_STEPS]);
        snap  = 1'b1;
        if (fade_idx < steps) begin
          fade_idx = fade_idx + 8'd1;
          snap     = (fade_idx >= steps);
        end
        for (int c = 0; c < rlf_pkg::CHANNELS; c++) begin
          if (snap) begin
            cur_col[c] = {goal_col[c], 8'h00};
          end else begin
            v = int'(cur_col[c]) + int'(col_inc[c]);
            if (v < 0) v = 0;
            if (v > int'(rlf_pkg::COLOUR_MAX)) v = int'(rlf_pkg::COLOUR_MAX);
            cur_col[c] = 16'(v);
          end
        end
        shift_word = rlf_pkg::FRAME_BITS'({cur_col[0][15:8], cur_col[1][15:8],
                                           cur_col[2][15:8]})
                     << (rlf_pkg::FRAME_BITS - 24);
        bits_todo  = rlf_pkg::BITS_W'(rlf_pkg::FRAME_BITS);
        load_phase(1'b1);
      end
      o.busy_res   = (bits_todo != 0);
      o.line_level = o.busy_res & high_phase;
    end
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // result side: random stall per item, field-by-field compare
  // ---------------------------------------------------------------------------
  task automatic compare_field(input string name, input logic want, input logic got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %b, got %b", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : result_side
    int hold;
    rlf_pkg::out_item_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else if (out_valid && !out_stall) begin
      results_seen++;
      if (out_data.frame_done === 1'b1) frames_seen++;
      if (line_q.size() == 0) begin
        errors++;
        $display("%0t: result %b with nothing expected", $time, out_data);
      end else begin
        want = line_q.pop_front();
        compare_field("line_level", want.line_level, out_data.line_level);
        compare_field("busy_res", want.busy_res, out_data.busy_res);
        compare_field("frame_done", want.frame_done, out_data.frame_done);
      end
      // wait a random number of cycles before taking the next item
      hold = $urandom_range(0, 12);
      out_stall <= (hold != 0);
      stall_left = hold;
    end else if (stall_left > 1) begin
      stall_left = stall_left - 1;
    end else begin
      stall_left = 0;
      out_stall <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------
  task automatic send_item(input rlf_pkg::in_item_t it, input bit typed = 1'b0,
                           input rlf_pkg::out_item_t typed_res = '0);
    int gap;
    rlf_pkg::out_item_t pred;
    gap = $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // item taken at this edge
    pred = predict_line(it);
    line_q.push_back(typed ? typed_res : pred);
    items_sent++;
    if (it.req_type != rlf_pkg::REQ_TICK) ctl_sent++;
  endtask

  // colour byte with the extremes showing up often
  function automatic logic [7:0] pick_colour();
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic rlf_pkg::in_item_t make_item(input logic [1:0] req);
    rlf_pkg::in_item_t it;
    it.req_type     = req;
    it.target_green = pick_colour();
    it.target_red   = pick_colour();
    it.target_blue  = pick_colour();
    return it;
  endfunction

  // tick until the frame being sent has left the line
  task automatic run_out_frame();
    while (bits_todo != 0) send_item(make_item(rlf_pkg::REQ_TICK));
  endtask

  // stop sending and let every owed result and any running division finish
  task automatic drain();
    in_valid <= 1'b0;
    while (line_q.size() != 0 || in_stall) @(posedge clk);
    repeat (DRAIN_PAD) @(posedge clk);
  endtask

  // register write, setup then access phase, then the bus is left idle; block must be quiet
  task automatic write_reg(input reg_idx_e idx, input logic [7:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 5'(int'(idx) * 4);
    pwdata  <= {24'h0, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    reg_val[idx] = val;
    @(posedge clk);
  endtask

  // directed table: typed results only where they are obvious
  row_t dir_tab [N_DIR] = '{
    // idle line, ignored request code
    '{ROW_ITEM, rlf_pkg::REQ_TICK,  8'h00, 8'h00, 8'h00, 1, 1'b1, 3'b000, REG_FADE_STEPS,
      8'h00},
    '{ROW_ITEM, REQ_NONE,           8'hFF, 8'hFF, 8'hFF, 1, 1'b1, 3'b000, REG_FADE_STEPS,
      8'h00},
    // short line timing, zero values act as one
    '{ROW_CFG,  REQ_NONE,           8'h00, 8'h00, 8'h00, 0, 1'b0, 3'b000, REG_ZERO_HIGH,
      8'h00},
    '{ROW_CFG,  REQ_NONE,           8'h00, 8'h00, 8'h00, 0, 1'b0, 3'b000, REG_ZERO_LOW,
      8'h01},
    '{ROW_CFG,  REQ_NONE,           8'h00, 8'h00, 8'h00, 0, 1'b0, 3'b000, REG_ONE_HIGH,
      8'h02},
    '{ROW_CFG,  REQ_NONE,           8'h00, 8'h00, 8'h00, 0, 1'b0, 3'b000, REG_ONE_LOW,
      8'h00},
    // frame with no fade pending sends the goal, a second one while busy is dropped
    '{ROW_ITEM, rlf_pkg::REQ_FRAME, 8'h00, 8'h00, 8'h00, 1, 1'b1, 3'b110, REG_FADE_STEPS,
      8'h00},
    '{ROW_ITEM, rlf_pkg::REQ_FRAME, 8'h00, 8'h00, 8'h00, 1, 1'b1, 3'b110, REG_FADE_STEPS,
      8'h00},
    '{ROW_ITEM, rlf_pkg::REQ_TICK,  8'h00, 8'h00, 8'h00, UNTIL_IDLE, 1'b0, 3'b000,
      REG_FADE_STEPS, 8'h00},
    // full white fade, retargeted while the first frame is on the line
    '{ROW_ITEM, rlf_pkg::REQ_SET,   8'hFF, 8'hFF, 8'hFF, 1, 1'b1, 3'b000, REG_FADE_STEPS,
      8'h00},
    '{ROW_ITEM, rlf_pkg::REQ_FRAME, 8'h00, 8'h00, 8'h00, 1, 1'b0, 3'b000, REG_FADE_STEPS,
      8'h00},
    '{ROW_ITEM, rlf_pkg::REQ_SET,   8'h12, 8'h34, 8'h56, 1, 1'b0, 3'b000, REG_FADE_STEPS,
      8'h00},
    '{ROW_ITEM, rlf_pkg::REQ_TICK,  8'h00, 8'h00, 8'h00, UNTIL_IDLE, 1'b0, 3'b000,
      REG_FADE_STEPS, 8'h00},
    // one-step increment, then steps raised so the second frame runs into both clamps
    '{ROW_CFG,  REQ_NONE,           8'h00, 8'h00, 8'h00, 0, 1'b0, 3'b000, REG_FADE_STEPS,
      8'h01},
    '{ROW_ITEM, rlf_pkg::REQ_SET,   8'h00, 8'hFF, 8'h00, 1, 1'b1, 3'b000, REG_FADE_STEPS,
      8'h00},
    '{ROW_CFG,  REQ_NONE,           8'h00, 8'h00, 8'h00, 0, 1'b0, 3'b000, REG_FADE_STEPS,
      8'hFF},
    '{ROW_ITEM, rlf_pkg::REQ_FRAME, 8'h00, 8'h00, 8'h00, 1, 1'b0, 3'b000, REG_FADE_STEPS,
      8'h00},
    '{ROW_ITEM, rlf_pkg::REQ_TICK,  8'h00, 8'h00, 8'h00, UNTIL_IDLE, 1'b0, 3'b000,
      REG_FADE_STEPS, 8'h00},
    '{ROW_ITEM, rlf_pkg::REQ_FRAME, 8'h00, 8'h00, 8'h00, 1, 1'b0, 3'b000, REG_FADE_STEPS,
      8'h00},
    '{ROW_ITEM, rlf_pkg::REQ_TICK,  8'h00, 8'h00, 8'h00, UNTIL_IDLE, 1'b0, 3'b000,
      REG_FADE_STEPS, 8'h00},
    // zero fade steps act as one, the frame snaps at once
    '{ROW_CFG,  REQ_NONE,           8'h00, 8'h00, 8'h00, 0, 1'b0, 3'b000, REG_FADE_STEPS,
      8'h00},
    '{ROW_ITEM, rlf_pkg::REQ_SET,   8'hFF, 8'h00, 8'hAA, 1, 1'b1, 3'b000, REG_FADE_STEPS,
      8'h00},
    '{ROW_ITEM, rlf_pkg::REQ_FRAME, 8'h00, 8'h00, 8'h00, 1, 1'b1, 3'b110, REG_FADE_STEPS,
      8'h00},
    '{ROW_ITEM, rlf_pkg::REQ_TICK,  8'h00, 8'h00, 8'h00, UNTIL_IDLE, 1'b0, 3'b000,
      REG_FADE_STEPS, 8'h00}
  };

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    row_t              row;
    rlf_pkg::in_item_t it;
    logic [7:0]        fade;
    int                phase_end;
    int                pick;
    int                nf;
    logic [1:0]        late_req;

    reset_line_state();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part
    for (int i = 0; i < N_DIR; i++) begin
      row = dir_tab[i];
      if (row.kind == ROW_CFG) begin
        drain();
        write_reg(row.idx, row.val);
      end else if (row.reps == UNTIL_IDLE) begin
        run_out_frame();
      end else begin
        it = '{row.req, row.g, row.r, row.b};
        repeat (row.reps) send_item(it, row.typed, rlf_pkg::out_item_t'(row.res));
      end
    end

    // random part: one register setting per phase
    for (int p = 0; p < N_PHASES; p++) begin
      drain();
      fade = 8'($urandom_range(0, 4));
      write_reg(REG_FADE_STEPS, fade);
      for (int k = 1; k < 5; k++) write_reg(reg_idx_e'(k), 8'($urandom_range(0, 2)));
      phase_end = items_sent + PHASE_ITEMS;

      while (items_sent < phase_end) begin
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
          // well-formed fade: new goal, then frames sent out one after another
          send_item(make_item(rlf_pkg::REQ_SET));
          nf = $urandom_range(1, int'(eff(fade)) + 2);
          if (nf > 10) nf = 10;
          for (int f = 0; f < nf && items_sent < phase_end; f++) begin
            send_item(make_item(rlf_pkg::REQ_FRAME));
            run_out_frame();
            repeat ($urandom_range(0, 2)) send_item(make_item(rlf_pkg::REQ_TICK));
          end
        end else if (pick < 8) begin
          // noise, any request code
          send_item(make_item(2'($urandom_range(0, 3))));
        end else begin
          // broken sequence: something lands while a frame is on the line
          send_item(make_item(rlf_pkg::REQ_FRAME));
          repeat ($urandom_range(1, 30)) send_item(make_item(rlf_pkg::REQ_TICK));
          case ($urandom_range(0, 2))
            0: late_req = rlf_pkg::REQ_SET;
            1: late_req = rlf_pkg::REQ_FRAME;
            default: late_req = REQ_NONE;
          endcase
          send_item(make_item(late_req));
          if (pick == 9) drain();
        end
      end
      run_out_frame();
    end

    // slowest line timing and longest fade: a frame starts, more lands while it is out
    drain();
    for (int k = 0; k < 5; k++) write_reg(reg_idx_e'(k), 8'hFF);
    send_item(make_item(rlf_pkg::REQ_SET));
    send_item(make_item(rlf_pkg::REQ_FRAME));
    repeat (LONG_TICKS) send_item(make_item(rlf_pkg::REQ_TICK));
    send_item(make_item(rlf_pkg::REQ_SET));
    send_item(make_item(rlf_pkg::REQ_FRAME));
    repeat (4) send_item(make_item(rlf_pkg::REQ_TICK));

    drain();
    $display("run covered %0d items (%0d non-tick), %0d results, %0d frames finished",
             items_sent, ctl_sent, results_seen, frames_seen);
    $display("fade steps 0..255, phase times 0..255, clamps, retargets and dropped frames");
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
